/* sv/goc_pkg.sv */
// Shared widths, constants and types for the gyro offset calibrate and scale unit.
`timescale 1ns / 1ps

package goc_pkg;

	// Field widths
	localparam int RAW_W  = 16;
	localparam int OFF_W  = 17;
	localparam int RATE_W = 14;

	// Rate scaling: multiply by 8, divide by 115 (exactly 1/14.375)
	localparam int MUL_SHIFT   = 3;
	localparam int RATE_DIV    = 115;
	localparam int RECIP_SHIFT = 20;
	localparam int RECIP_W     = 14;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** RECIP_SHIFT) / RATE_DIV);

	// Datapath widths in the scaler
	localparam int VSUM_W = OFF_W + 1;
	localparam int MAG_W  = OFF_W;
	localparam int PROD_W = MAG_W + RECIP_W;
	localparam int Q_W    = PROD_W - (RECIP_SHIFT - MUL_SHIFT);
	localparam int REM_W  = Q_W + 7;

	typedef logic signed [RAW_W-1:0]  raw_t;
	typedef logic signed [OFF_W-1:0]  off_t;
	typedef logic signed [RATE_W-1:0] rate_t;

	// Stage enables for the calibration front end
	typedef struct packed {
		logic accept;
		logic en_s1;
		logic en_s2;
		logic vld_s1;
	} calib_ctl_t;

	// Stage enables for the scaler back end
	typedef struct packed {
		logic en_s3;
		logic en_s4;
		logic en_out;
	} scale_ctl_t;

endpackage

/* sv/goc_in_if.sv */
// Input channel: one raw gyro sample and its opcode per beat.
`timescale 1ns / 1ps

interface goc_in_if;
	logic                 valid;
	logic                 ready;
	logic                 opcode;
	logic signed [15:0]   raw_x;
	logic signed [15:0]   raw_y;
	logic signed [15:0]   raw_z;

	modport source (output valid, output opcode, output raw_x, output raw_y, output raw_z,
		input ready);
	modport sink (input valid, input opcode, input raw_x, input raw_y, input raw_z,
		output ready);
endinterface

/* sv/goc_out_if.sv */
// Output channel: three scaled rates and the calibration flag per beat.
`timescale 1ns / 1ps

interface goc_out_if;
	logic                 valid;
	logic                 ready;
	logic signed [13:0]   rate_x;
	logic signed [13:0]   rate_y;
	logic signed [13:0]   rate_z;
	logic                 calibration_done;

	modport source (output valid, output rate_x, output rate_y, output rate_z,
		output calibration_done, input ready);
	modport sink (input valid, input rate_x, input rate_y, input rate_z,
		input calibration_done, output ready);
endinterface

/* sv/gyro_offset_calibrate_and_scale_unit.sv */
// Top level: gyro zero-rate offset calibration and rate scaling pipeline.
// Path: a sample accepted at one edge enters calibration stage 1 at that edge and then
// passes through calibration stage 2, two scaler stages and the output register.
// Throughput: one sample per cycle; a stage holds only while its successor is full and stalled.
// Reset clears the running sums, the batch count, the offsets and all valid flags.
`timescale 1ns / 1ps

module gyro_offset_calibrate_and_scale_unit #(
	parameter int CAL_SHIFT = 7
) (
	input  logic      clk,
	input  logic      arst_n,
	goc_in_if.sink    samples,
	goc_out_if.source rates
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, out_vld_q;
	logic en_s1, en_s2, en_s3, en_s4, en_out;
	logic done_s2, done_s3, done_s4, done_q;

	goc_pkg::calib_ctl_t cctl;
	goc_pkg::scale_ctl_t sctl;
	goc_pkg::raw_t       raw [3];
	goc_pkg::raw_t       raw_s2 [3];
	goc_pkg::off_t       off_s2 [3];
	goc_pkg::rate_t      rate [3];

	// Stage enables: a stage loads when empty or when its successor moves
	assign en_out = !out_vld_q || rates.ready;
	assign en_s4  = !vld_s4 || en_out;
	assign en_s3  = !vld_s3 || en_s4;
	assign en_s2  = !vld_s2 || en_s3;
	assign en_s1  = !vld_s1 || en_s2;

	assign samples.ready = en_s1;

	assign cctl = '{accept: samples.valid && en_s1, en_s1: en_s1, en_s2: en_s2,
		vld_s1: vld_s1};
	assign sctl = '{en_s3: en_s3, en_s4: en_s4, en_out: en_out};

	assign raw[0] = samples.raw_x;
	assign raw[1] = samples.raw_y;
	assign raw[2] = samples.raw_z;

	goc_calib #(
		.CAL_SHIFT(CAL_SHIFT)
	) u_calib (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (cctl),
		.cal     (samples.opcode),
		.raw     (raw),
		.raw_s2  (raw_s2),
		.off_s2  (off_s2),
		.done_s2 (done_s2)
	);

	// One scaler per axis
	for (genvar a = 0; a < 3; a++) begin : g_axis
		goc_scale u_scale (
			.clk    (clk),
			.ctl    (sctl),
			.raw    (raw_s2[a]),
			.off    (off_s2[a]),
			.rate_q (rate[a])
		);
	end

	// Valid flags and the calibration flag along the pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			out_vld_q <= 1'b0;
			done_s3   <= 1'b0;
			done_s4   <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= samples.valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) begin
				vld_s3  <= vld_s2;
				done_s3 <= done_s2;
			end
			if (en_s4) begin
				vld_s4  <= vld_s3;
				done_s4 <= done_s3;
			end
			if (en_out) begin
				out_vld_q <= vld_s4;
				done_q    <= done_s4;
			end
		end
	end

	assign rates.valid            = out_vld_q;
	assign rates.rate_x           = rate[0];
	assign rates.rate_y           = rate[1];
	assign rates.rate_z           = rate[2];
	assign rates.calibration_done = done_q;

	// Input stalls only when every stage is full and the output is blocked
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!samples.ready |-> (out_vld_q && !rates.ready && vld_s1 && vld_s4))
		else $error("input stalled with room in the pipe");

	// An accepted beat occupies stage 1 on the next cycle
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(samples.valid && samples.ready) |=> vld_s1)
		else $error("accepted beat lost at stage 1");

	// A result appears only from a filled last stage
	a_out_from_s4: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(vld_s4))
		else $error("result valid without a beat in stage 4");

	// The calibration flag never leaves without a valid result
	a_done_with_valid: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> out_vld_q)
		else $error("calibration flag on an empty output");

endmodule

/* sv/goc_calib.sv */
// Calibration front end: running sums, batch count, offsets and the first two stages.
`timescale 1ns / 1ps

module goc_calib #(
	parameter int CAL_SHIFT = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  goc_pkg::calib_ctl_t ctl,
	input  logic                cal,
	input  goc_pkg::raw_t       raw [3],
	output goc_pkg::raw_t       raw_s2 [3],
	output goc_pkg::off_t       off_s2 [3],
	output logic                done_s2
);

	localparam int SUM_W = goc_pkg::RAW_W + CAL_SHIFT;

	logic signed [SUM_W-1:0]     sum_q [3];
	logic signed [SUM_W-1:0]     sum_nx [3];
	logic signed [SUM_W-1:0]     tot_s1 [3];
	logic signed [SUM_W-1:0]     biased [3];
	logic signed [goc_pkg::RAW_W-1:0] quot [3];
	logic [CAL_SHIFT-1:0]        cnt_q;
	logic                        done_nx;
	logic                        done_s1;
	goc_pkg::raw_t               raw_s1 [3];
	goc_pkg::off_t               off_q [3];
	goc_pkg::off_t               off_new [3];
	goc_pkg::off_t               off_eff [3];

	// Batch completes on the last calibration beat
	assign done_nx = ctl.accept && cal && (&cnt_q);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum_nx[i] = sum_q[i] + SUM_W'(raw[i]);
			// truncate toward zero: bias negative sums before the shift
			biased[i] = tot_s1[i] + $signed({{(SUM_W-CAL_SHIFT){1'b0}},
				{CAL_SHIFT{tot_s1[i][SUM_W-1]}}});
			quot[i] = biased[i][SUM_W-1:CAL_SHIFT];
			off_new[i] = -(goc_pkg::OFF_W'(quot[i]));
			off_eff[i] = done_s1 ? off_new[i] : off_q[i];
		end
	end

	// Running sums and batch count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) sum_q[i] <= '0;
			cnt_q <= '0;
		end else if (ctl.accept && cal) begin
			cnt_q <= cnt_q + 1'b1;
			for (int i = 0; i < 3; i++) sum_q[i] <= done_nx ? '0 : sum_nx[i];
		end
	end

	// Offsets change as the completing beat leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) off_q[i] <= '0;
		end else if (ctl.en_s2 && ctl.vld_s1 && done_s1) begin
			for (int i = 0; i < 3; i++) off_q[i] <= off_new[i];
		end
	end

	// Stage flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
			done_s2 <= 1'b0;
		end else begin
			if (ctl.en_s1) done_s1 <= done_nx;
			if (ctl.en_s2) done_s2 <= done_s1;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			for (int i = 0; i < 3; i++) begin
				raw_s1[i] <= raw[i];
				tot_s1[i] <= sum_nx[i];
			end
		end
		if (ctl.en_s2) begin
			for (int i = 0; i < 3; i++) begin
				raw_s2[i] <= raw_s1[i];
				off_s2[i] <= off_eff[i];
			end
		end
	end

endmodule

/* sv/goc_scale.sv */
// One axis of the rate scaler: (raw + offset) * 8 / 115, truncated toward zero.
`timescale 1ns / 1ps

module goc_scale (
	input  logic                clk,
	input  goc_pkg::scale_ctl_t ctl,
	input  goc_pkg::raw_t       raw,
	input  goc_pkg::off_t       off,
	output goc_pkg::rate_t      rate_q
);

	logic signed [goc_pkg::VSUM_W-1:0] vsum;
	logic signed [goc_pkg::VSUM_W-1:0] vabs;
	logic [goc_pkg::MAG_W-1:0]         mag_s3;
	logic                              neg_s3;
	logic [goc_pkg::MAG_W-1:0]         mag_s4;
	logic                              neg_s4;
	logic [goc_pkg::PROD_W-1:0]        prod_s4;
	logic [goc_pkg::Q_W-1:0]           q_est;
	logic [goc_pkg::REM_W-1:0]         num;
	logic [goc_pkg::REM_W-1:0]         qmul;
	logic [goc_pkg::REM_W-1:0]         rem;
	logic [goc_pkg::Q_W-1:0]           quo;

	// Sign and magnitude of the offset-corrected sample
	always_comb begin
		vsum = goc_pkg::VSUM_W'(raw) + goc_pkg::VSUM_W'(off);
		vabs = vsum[goc_pkg::VSUM_W-1] ? -vsum : vsum;
	end

	// Quotient estimate from the reciprocal, then one correction step
	always_comb begin
		q_est = prod_s4[goc_pkg::PROD_W-1:goc_pkg::RECIP_SHIFT-goc_pkg::MUL_SHIFT];
		num   = goc_pkg::REM_W'({mag_s4, {goc_pkg::MUL_SHIFT{1'b0}}});
		qmul  = goc_pkg::REM_W'(q_est) * goc_pkg::REM_W'(goc_pkg::RATE_DIV);
		rem   = num - qmul;
		quo   = (rem >= goc_pkg::REM_W'(goc_pkg::RATE_DIV)) ? q_est + 1'b1 : q_est;
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			mag_s3 <= vabs[goc_pkg::MAG_W-1:0];
			neg_s3 <= vsum[goc_pkg::VSUM_W-1];
		end
		if (ctl.en_s4) begin
			prod_s4 <= goc_pkg::PROD_W'(mag_s3) * goc_pkg::PROD_W'(goc_pkg::RECIP);
			mag_s4  <= mag_s3;
			neg_s4  <= neg_s3;
		end
		if (ctl.en_out) begin
			rate_q <= neg_s4 ? -(goc_pkg::RATE_W'(quo)) : goc_pkg::RATE_W'(quo);
		end
	end

endmodule

/* dv/gyro_offset_calibrate_and_scale_unit_tb.sv */
// Self-checking testbench for the gyro offset calibrate and scale unit.
`timescale 1ns / 1ps

module gyro_offset_calibrate_and_scale_unit_tb;

	localparam int CAL_SHIFT  = 7;
	localparam int BATCH      = 1 << CAL_SHIFT;
	localparam int SUM_W      = goc_pkg::RAW_W + CAL_SHIFT;
	localparam int DRAIN_CYC  = 20;
	localparam int RAW_MAX    = 32767;
	localparam int RAW_MIN    = -32768;

	localparam logic OP_MEASURE = 1'b0;
	localparam logic OP_CAL     = 1'b1;

	typedef struct {
		goc_pkg::rate_t rate [3];
		logic           done;
	} rate_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	goc_in_if  samples_if ();
	goc_out_if rates_if ();

	gyro_offset_calibrate_and_scale_unit #(
		.CAL_SHIFT (CAL_SHIFT)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.rates   (rates_if)
	);

	always #2 clk = ~clk;

	// Predictor state: running sums, batch count and the live offsets
	logic signed [SUM_W-1:0] cal_sum [3];
	int                      cal_count;
	goc_pkg::off_t           cal_off [3];

	rate_beat_t pending_rates [$];
	int         mismatch_count = 0;
	int         burst_left = 0;

	// Sender-side burst bookkeeping lives in burst_left; receiver pattern below
	int rx_mode = 0;
	int rx_left = 0;

	// Expected rates for one sample; updates the calibration state
	function automatic rate_beat_t predict_rates(input logic op, input goc_pkg::raw_t x,
			input goc_pkg::raw_t y, input goc_pkg::raw_t z);
		rate_beat_t    r;
		goc_pkg::raw_t raw [3];
		longint        q;
		raw[0] = x;
		raw[1] = y;
		raw[2] = z;
		r.done = 1'b0;
		if (op == OP_CAL) begin
			for (int i = 0; i < 3; i++)
				cal_sum[i] = cal_sum[i] + SUM_W'(raw[i]);
			cal_count++;
			if (cal_count >= BATCH) begin
				// negated mean, truncated toward zero
				for (int i = 0; i < 3; i++) begin
					q = -longint'(cal_sum[i]) / longint'(BATCH);
					cal_off[i] = goc_pkg::off_t'(q);
					cal_sum[i] = '0;
				end
				cal_count = 0;
				r.done = 1'b1;
			end
		end
		for (int i = 0; i < 3; i++) begin
			q = ((longint'(raw[i]) + longint'(cal_off[i])) *
				longint'(1 << goc_pkg::MUL_SHIFT)) / longint'(goc_pkg::RATE_DIV);
			r.rate[i] = goc_pkg::rate_t'(q);
		end
		return r;
	endfunction

	function automatic goc_pkg::raw_t near_value(input int center, input int spread);
		int v;
		v = center + int'($urandom_range(0, 2 * spread)) - spread;
		if (v > RAW_MAX)
			v = RAW_MAX;
		if (v < RAW_MIN)
			v = RAW_MIN;
		return goc_pkg::raw_t'(v);
	endfunction

	function automatic goc_pkg::raw_t any_value();
		return goc_pkg::raw_t'($urandom_range(0, 65535));
	endfunction

	// Send one beat; called at a falling edge, returns at a falling edge
	task automatic send_sample(input logic op, input goc_pkg::raw_t x, input goc_pkg::raw_t y,
			input goc_pkg::raw_t z);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				samples_if.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		samples_if.valid  <= 1'b1;
		samples_if.opcode <= op;
		samples_if.raw_x  <= x;
		samples_if.raw_y  <= y;
		samples_if.raw_z  <= z;
		do
			@(posedge clk);
		while (!samples_if.ready);
		pending_rates.push_back(predict_rates(op, x, y, z));
		@(negedge clk);
	endtask

	// One calibration batch with measurement beats mixed in at random places
	task automatic run_cal_batch(input int cx, input int cy, input int cz, input int spread,
			input int meas_count);
		int cal_left;
		int meas_left;
		cal_left = BATCH;
		meas_left = meas_count;
		while (cal_left > 0 || meas_left > 0) begin
			if (meas_left > 0 && $urandom_range(0, cal_left + meas_left - 1) < meas_left) begin
				send_sample(OP_MEASURE, any_value(), any_value(), any_value());
				meas_left--;
			end else begin
				send_sample(OP_CAL, near_value(cx, spread), near_value(cy, spread),
					near_value(cz, spread));
				cal_left--;
			end
		end
	endtask

	task automatic send_extremes();
		send_sample(OP_MEASURE, goc_pkg::raw_t'(RAW_MAX), goc_pkg::raw_t'(RAW_MIN), 16'sd0);
		send_sample(OP_MEASURE, goc_pkg::raw_t'(RAW_MIN), goc_pkg::raw_t'(RAW_MAX), -16'sd1);
		send_sample(OP_MEASURE, 16'sd0, 16'sd0, 16'sd0);
		send_sample(OP_MEASURE, 16'sd115, -16'sd115, 16'sd14);
	endtask

	// Measurement beats before any calibration: offsets are still zero
	task automatic test_raw_extremes();
		send_extremes();
		send_sample(OP_MEASURE, 16'sd1, -16'sd1, 16'sd114);
		send_sample(OP_MEASURE, -16'sd14, 16'sd15, -16'sd16);
		send_sample(OP_MEASURE, 16'sh5555, 16'shAAAA, 16'sh7FFE);
		send_sample(OP_MEASURE, 16'shAAAA, 16'sh5555, 16'sh8001);
	endtask

	// Batches pinned at full scale on x and y push those offsets to their limits
	task automatic test_cal_extremes();
		run_cal_batch(RAW_MAX, RAW_MIN, -1, 0, 0);
		send_extremes();
		run_cal_batch(RAW_MIN, RAW_MAX, 127, 0, 0);
		send_extremes();
	endtask

	// Well-formed batches with random centers and spreads
	task automatic test_random_batches();
		int spread;
		for (int b = 0; b < 7; b++) begin
			case ($urandom_range(0, 3))
				0: spread = 0;
				1: spread = $urandom_range(1, 8);
				2: spread = $urandom_range(9, 512);
				default: spread = 32768;
			endcase
			run_cal_batch(int'($urandom_range(0, 65535)) - 32768,
				int'($urandom_range(0, 65535)) - 32768,
				int'($urandom_range(0, 65535)) - 32768, spread, $urandom_range(5, 45));
		end
	endtask

	// Random opcodes and full-range samples
	task automatic test_noise();
		for (int n = 0; n < 200; n++)
			send_sample(logic'($urandom_range(0, 1)), any_value(), any_value(), any_value());
	endtask

	// Receiver stall pattern: switches between several modes
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(20, 200);
		end
		rx_left--;
		case (rx_mode)
			0: rates_if.ready <= 1'b1;
			1: rates_if.ready <= logic'($urandom_range(0, 1));
			2: rates_if.ready <= ($urandom_range(0, 3) == 0);
			default: rates_if.ready <= ((rx_left % 8) < 5);
		endcase
	end

	// Compare each result beat with the oldest prediction
	always @(posedge clk) begin
		rate_beat_t     exp_beat;
		goc_pkg::rate_t act [3];
		string          axis_name [3];
		if (arst_n && rates_if.valid && rates_if.ready) begin
			act[0] = rates_if.rate_x;
			act[1] = rates_if.rate_y;
			act[2] = rates_if.rate_z;
			axis_name = '{"rate_x", "rate_y", "rate_z"};
			if (pending_rates.size() == 0) begin
				$display("%0t unexpected beat: expected none, actual %0d %0d %0d done %0b",
					$time, act[0], act[1], act[2], rates_if.calibration_done);
				mismatch_count++;
			end else begin
				exp_beat = pending_rates.pop_front();
				for (int i = 0; i < 3; i++)
					if (act[i] !== exp_beat.rate[i]) begin
						$display("%0t %s mismatch: expected %0d, actual %0d", $time,
							axis_name[i], exp_beat.rate[i], act[i]);
						mismatch_count++;
					end
				if (rates_if.calibration_done !== exp_beat.done) begin
					$display("%0t calibration_done mismatch: expected %0b, actual %0b",
						$time, exp_beat.done, rates_if.calibration_done);
					mismatch_count++;
				end
			end
		end
	end

	// Main sequence
	initial begin
		samples_if.valid  = 1'b0;
		samples_if.opcode = OP_MEASURE;
		samples_if.raw_x  = '0;
		samples_if.raw_y  = '0;
		samples_if.raw_z  = '0;
		rates_if.ready    = 1'b0;
		for (int i = 0; i < 3; i++) begin
			cal_sum[i] = '0;
			cal_off[i] = '0;
		end
		cal_count = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_raw_extremes();
		test_cal_extremes();
		test_random_batches();
		test_noise();
		samples_if.valid <= 1'b0;

		wait (pending_rates.size() == 0);
		repeat (DRAIN_CYC) @(posedge clk);
		if (mismatch_count == 0 && pending_rates.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

endmodule
